@@ hw/rtl/mesh_vertex_normal_engine_macros.svh @@
// Assertion helpers for the top-level file that checks the engine.
// Every check is clocked on clk and switched off while rst is high.
`ifndef MESH_VERTEX_NORMAL_ENGINE_MACROS_SVH
`define MESH_VERTEX_NORMAL_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mvn_pkg.sv @@
`default_nettype none

package mvn_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int ADDR_W       = 10;
  localparam int STORE_DEPTH  = 1 << ADDR_W;
  localparam int ACCUM_WIDTH  = 21;
  localparam int COORD_W      = 16;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = 36;
  localparam int NORM_W       = 16;
  localparam int UNIT_ONE     = 16384;
  localparam int FRAC_W       = 14;
  localparam int VTX_W        = 3 * COORD_W;
  localparam int ACC_W        = 3 * ACCUM_WIDTH;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef logic signed [CROSS_W-1:0] wide_t;

  typedef struct packed {
    mode_t                     mode;
    logic [ADDR_W-1:0]         first_index;
    logic [ADDR_W-1:0]         second_index;
    logic [ADDR_W-1:0]         third_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     result_kind;
    logic                     degenerate;
  } result_t;

  // Head of the command queue, front to back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic  start;
    wide_t x;
    wide_t y;
    wide_t z;
  } norm_req_t;

  typedef struct packed {
    logic                     done;
    logic                     degenerate;
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } norm_rsp_t;

  function automatic logic index_ok(logic [ADDR_W-1:0] idx);
    return int'(idx) < VERTEX_COUNT;
  endfunction

  // Saturating add of a normal component into an accumulator component.
  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
      logic signed [ACCUM_WIDTH-1:0] a, logic signed [NORM_W-1:0] b);
    logic signed [ACCUM_WIDTH:0]   s;
    logic signed [ACCUM_WIDTH-1:0] r;
    s = (ACCUM_WIDTH+1)'(a) + (ACCUM_WIDTH+1)'(b);
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      r = s[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                         : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end else begin
      r = s[ACCUM_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mvn_front.sv @@
`default_nettype none

module mvn_front import mvn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  input  back_stat_t stat,
  output q_out_t     q
);

  cmd_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       push;
  logic       pop;

  // Unused mode codes are dropped here and never reach the back end.
  assign busy   = stat.clearing || (count == 2'd2);
  assign accept = start && !busy;
  assign push   = accept && (cmd.mode != MODE_NONE);
  assign pop    = stat.pop && (count != 2'd0);

  assign q.valid = (count != 2'd0);
  assign q.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mvn_norm.sv @@
`default_nettype none

module mvn_norm import mvn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  localparam int SCALE_HI = 30;
  localparam int SCALE_LO = 29;
  localparam int SQ_W     = 2 * SCALE_HI;
  localparam int SUM_W    = 64;
  localparam int LEN_W    = 32;
  localparam int NUM_W    = SCALE_HI + FRAC_W + 1;
  localparam int Q_W      = 16;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCALE, S_SQ, S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DONE
  } state_t;

  state_t                   state;
  logic [CROSS_W-1:0]       m [0:2];
  logic [2:0]               neg;
  logic [CROSS_W-1:0]       big;
  logic [1:0]               cnt;
  logic [SQ_W-1:0]          sq;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         root;
  logic [SUM_W-1:0]         bitv;
  logic [Q_W-1:0]           numlo;
  logic [LEN_W-1:0]         rem;
  logic [Q_W-1:0]           q;
  logic [3:0]               bidx;
  logic                     degen;
  logic signed [NORM_W-1:0] ox;
  logic signed [NORM_W-1:0] oy;
  logic signed [NORM_W-1:0] oz;

  logic [CROSS_W-1:0] bigc;
  logic [CROSS_W-1:0] msel;
  logic               nsel;
  logic [SUM_W-1:0]   trial;
  logic [NUM_W-1:0]   numc;
  logic [LEN_W-1:0]   len;
  logic [LEN_W:0]     rem2;
  logic               qbit;
  logic [Q_W-1:0]     qn;
  logic [Q_W-1:0]     qc;
  logic [NORM_W-1:0]  qs;

  always_comb begin
    bigc = m[0];
    if (m[1] > bigc) begin
      bigc = m[1];
    end
    if (m[2] > bigc) begin
      bigc = m[2];
    end
    case (cnt)
      2'd0:    begin msel = m[0]; nsel = neg[0]; end
      2'd1:    begin msel = m[1]; nsel = neg[1]; end
      default: begin msel = m[2]; nsel = neg[2]; end
    endcase
    trial = root + bitv;
    len   = root[LEN_W-1:0];
    // Rounded numerator: |m| * one + len / 2.
    numc  = {1'b0, msel[SCALE_HI-1:0], {FRAC_W{1'b0}}} + NUM_W'(root[LEN_W-1:1]);
    rem2  = {rem, numlo[bidx]};
    qbit  = (rem2 >= {1'b0, len});
    qn    = {q[Q_W-2:0], qbit};
    qc    = (qn > Q_W'(UNIT_ONE)) ? Q_W'(UNIT_ONE) : qn;
    qs    = nsel ? (NORM_W'(0) - qc) : qc;
  end

  assign rsp.done       = (state == S_DONE);
  assign rsp.degenerate = degen;
  assign rsp.x          = ox;
  assign rsp.y          = oy;
  assign rsp.z          = oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            neg  <= {req.x < 0, req.y < 0, req.z < 0};
            m[0] <= (req.x < 0) ? $unsigned(-req.x) : $unsigned(req.x);
            m[1] <= (req.y < 0) ? $unsigned(-req.y) : $unsigned(req.y);
            m[2] <= (req.z < 0) ? $unsigned(-req.z) : $unsigned(req.z);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // neg was captured x-first; flip it so neg[0] belongs to x.
          neg <= {neg[0], neg[1], neg[2]};
          if (bigc == '0) begin
            ox    <= '0;
            oy    <= '0;
            oz    <= '0;
            degen <= 1'b1;
            state <= S_DONE;
          end else begin
            degen <= 1'b0;
            big   <= bigc;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (big[CROSS_W-1:SCALE_HI] != '0) begin
            m[0] <= m[0] >> 1;
            m[1] <= m[1] >> 1;
            m[2] <= m[2] >> 1;
            big  <= big >> 1;
          end else if (!big[SCALE_LO]) begin
            m[0] <= m[0] << 1;
            m[1] <= m[1] << 1;
            m[2] <= m[2] << 1;
            big  <= big << 1;
          end else begin
            cnt   <= 2'd0;
            sum   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt != 2'd3) begin
            sq <= msel[SCALE_HI-1:0] * msel[SCALE_HI-1:0];
          end
          if (cnt != 2'd0) begin
            sum <= sum + SUM_W'(sq);
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            root  <= '0;
            bitv  <= SUM_W'(1) << (SUM_W - 2);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sum >= trial) begin
            sum  <= sum - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == SUM_W'(1)) begin
            cnt   <= 2'd0;
            state <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          rem   <= LEN_W'(numc[NUM_W-1:Q_W]);
          numlo <= numc[Q_W-1:0];
          q     <= '0;
          bidx  <= 4'(Q_W - 1);
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          rem  <= qbit ? LEN_W'(rem2 - {1'b0, len}) : rem2[LEN_W-1:0];
          q    <= qn;
          bidx <= bidx - 4'd1;
          if (bidx == 4'd0) begin
            case (cnt)
              2'd0:    ox <= qs;
              2'd1:    oy <= qs;
              default: oz <= qs;
            endcase
            if (cnt == 2'd2) begin
              state <= S_DONE;
            end else begin
              cnt   <= cnt + 2'd1;
              state <= S_DIV_INIT;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mvn_back.sv @@
`default_nettype none

module mvn_back import mvn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_out_t     q,
  output back_stat_t stat,
  output logic       done,
  output result_t    result
);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_LOAD, B_TRI_RD, B_EDGE, B_CROSS, B_NORM_GO, B_NORM_WAIT,
    B_ACC_RD, B_ACC_WR, B_RD_ACC, B_RD_WAIT
  } state_t;

  state_t                    state;
  cmd_t                      cur;
  logic [ADDR_W-1:0]         clr;
  logic [2:0]                cnt;
  logic [1:0]                k;
  logic [VTX_W-1:0]          pv [0:2];
  logic signed [EDGE_W-1:0]  ea [0:2];
  logic signed [EDGE_W-1:0]  eb [0:2];
  logic signed [PROD_W-1:0]  prod;
  wide_t                     c [0:2];
  logic signed [NORM_W-1:0]  n [0:2];

  logic [VTX_W-1:0]  vmem [0:STORE_DEPTH-1];
  logic [ACC_W-1:0]  amem [0:STORE_DEPTH-1];
  logic [ADDR_W-1:0] vaddr;
  logic              vwe;
  logic [VTX_W-1:0]  vwdata;
  logic [VTX_W-1:0]  vrdata;
  logic [ADDR_W-1:0] aaddr;
  logic              awe;
  logic [ACC_W-1:0]  awdata;
  logic [ACC_W-1:0]  ardata;

  norm_req_t                req;
  norm_rsp_t                rsp;
  logic signed [EDGE_W-1:0] opa;
  logic signed [EDGE_W-1:0] opb;
  logic [ADDR_W-1:0]        kidx;
  logic [ADDR_W-1:0]        ridx;
  logic                     rok;

  function automatic logic [ADDR_W-1:0] corner(cmd_t cm, logic [1:0] sel);
    case (sel)
      2'd0:    return cm.first_index;
      2'd1:    return cm.second_index;
      default: return cm.third_index;
    endcase
  endfunction

  function automatic logic signed [EDGE_W-1:0] coord(logic [VTX_W-1:0] w, logic [1:0] sel);
    case (sel)
      2'd0:    return EDGE_W'($signed(w[VTX_W-1:2*COORD_W]));
      2'd1:    return EDGE_W'($signed(w[2*COORD_W-1:COORD_W]));
      default: return EDGE_W'($signed(w[COORD_W-1:0]));
    endcase
  endfunction

  function automatic wide_t acc_part(logic [ACC_W-1:0] w, logic [1:0] sel);
    case (sel)
      2'd0:    return CROSS_W'($signed(w[ACC_W-1:2*ACCUM_WIDTH]));
      2'd1:    return CROSS_W'($signed(w[2*ACCUM_WIDTH-1:ACCUM_WIDTH]));
      default: return CROSS_W'($signed(w[ACCUM_WIDTH-1:0]));
    endcase
  endfunction

  mvn_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign stat.clearing = (state == B_CLEAR);
  assign stat.pop      = (state == B_IDLE) && q.valid;

  assign req.start = (state == B_NORM_GO);
  assign req.x     = c[0];
  assign req.y     = c[1];
  assign req.z     = c[2];

  always_comb begin
    kidx = corner(cur, k);
    ridx = corner(cur, cnt[1:0] - 2'd1);
    rok  = index_ok(ridx);
    case (cnt)
      3'd0:    begin opa = ea[1]; opb = eb[2]; end
      3'd1:    begin opa = ea[2]; opb = eb[1]; end
      3'd2:    begin opa = ea[2]; opb = eb[0]; end
      3'd3:    begin opa = ea[0]; opb = eb[2]; end
      3'd4:    begin opa = ea[0]; opb = eb[1]; end
      default: begin opa = ea[1]; opb = eb[0]; end
    endcase

    vaddr  = cur.first_index;
    vwe    = 1'b0;
    vwdata = {cur.pos_x, cur.pos_y, cur.pos_z};
    if (state == B_TRI_RD) begin
      vaddr = corner(cur, cnt[1:0]);
    end
    if (state == B_LOAD) begin
      vwe = index_ok(cur.first_index);
    end

    aaddr  = cur.first_index;
    awe    = 1'b0;
    awdata = '0;
    case (state)
      B_CLEAR: begin
        aaddr = clr;
        awe   = 1'b1;
      end
      B_LOAD: begin
        awe = index_ok(cur.first_index);
      end
      B_ACC_RD: begin
        aaddr = kidx;
      end
      B_ACC_WR: begin
        aaddr  = kidx;
        awe    = index_ok(kidx);
        awdata = {sat_add($signed(ardata[ACC_W-1:2*ACCUM_WIDTH]), n[0]),
                  sat_add($signed(ardata[2*ACCUM_WIDTH-1:ACCUM_WIDTH]), n[1]),
                  sat_add($signed(ardata[ACCUM_WIDTH-1:0]), n[2])};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vaddr] <= vwdata;
    end
    vrdata <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (awe) begin
      amem[aaddr] <= awdata;
    end
    ardata <= amem[aaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q.valid) begin
            cur <= q.cmd;
            cnt <= 3'd0;
            case (q.cmd.mode)
              MODE_LOAD: state <= B_LOAD;
              MODE_TRI:  state <= B_TRI_RD;
              MODE_READ: state <= B_RD_ACC;
              default:   state <= B_IDLE;
            endcase
          end
        end
        B_LOAD: begin
          state <= B_IDLE;
        end
        B_TRI_RD: begin
          if (cnt != 3'd0) begin
            pv[0] <= pv[1];
            pv[1] <= pv[2];
            pv[2] <= rok ? vrdata : '0;
          end
          if (cnt == 3'd3) begin
            state <= B_EDGE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        B_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            ea[i] <= coord(pv[1], 2'(i)) - coord(pv[0], 2'(i));
            eb[i] <= coord(pv[2], 2'(i)) - coord(pv[0], 2'(i));
          end
          cnt   <= 3'd0;
          state <= B_CROSS;
        end
        B_CROSS: begin
          if (cnt != 3'd6) begin
            prod <= opa * opb;
          end
          case (cnt)
            3'd1:    c[0] <= CROSS_W'(prod);
            3'd2:    c[0] <= c[0] - CROSS_W'(prod);
            3'd3:    c[1] <= CROSS_W'(prod);
            3'd4:    c[1] <= c[1] - CROSS_W'(prod);
            3'd5:    c[2] <= CROSS_W'(prod);
            3'd6:    c[2] <= c[2] - CROSS_W'(prod);
            default: begin
            end
          endcase
          if (cnt == 3'd6) begin
            state <= B_NORM_GO;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        B_NORM_GO: begin
          state <= B_NORM_WAIT;
        end
        B_NORM_WAIT: begin
          if (rsp.done) begin
            done               <= 1'b1;
            result.norm_x      <= rsp.x;
            result.norm_y      <= rsp.y;
            result.norm_z      <= rsp.z;
            result.degenerate  <= rsp.degenerate;
            result.result_kind <= (cur.mode == MODE_READ) ? KIND_VERTEX : KIND_FACE;
            n[0] <= rsp.x;
            n[1] <= rsp.y;
            n[2] <= rsp.z;
            k    <= 2'd0;
            state <= (cur.mode == MODE_READ) ? B_IDLE : B_ACC_RD;
          end
        end
        B_ACC_RD: begin
          state <= B_ACC_WR;
        end
        B_ACC_WR: begin
          if (k == 2'd2) begin
            state <= B_IDLE;
          end else begin
            k     <= k + 2'd1;
            state <= B_ACC_RD;
          end
        end
        B_RD_ACC: begin
          state <= B_RD_WAIT;
        end
        B_RD_WAIT: begin
          for (int i = 0; i < 3; i++) begin
            c[i] <= index_ok(cur.first_index) ? acc_part(ardata, 2'(i)) : '0;
          end
          state <= B_NORM_GO;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mesh_vertex_normal_engine.sv @@
`default_nettype none
`include "mesh_vertex_normal_engine_macros.svh"

// Averaged vertex normal engine.
// A command beat is taken on a rising edge with start high and busy low; cmd
// carries the mode, up to three vertex indices and a Q7.8 position. Mode 0
// loads a vertex and clears its accumulator, mode 1 computes the unit face
// normal of a triangle and adds it to its three corners, mode 2 returns the
// normalized accumulator of one vertex. Mode 3 is dropped at the door.
// Each result beat is shown on result for exactly one cycle with done high;
// the receiver cannot stall, so results never back up into the engine.
// A two-entry command queue sits ahead of the sequencer, so busy rises only
// when both entries are taken or while the accumulator clear runs.
// A load passes through the sequencer's dispatch and load states. A triangle
// is dispatched, reads its three corners, forms its edges, builds the cross
// product, starts the normalizer and waits for it, then does an accumulator
// read-modify-write for each corner. A read fetches the accumulator and
// starts the normalizer. The normalizer checks for a zero vector, scales the
// vector one bit per cycle, squares and sums the components, takes a
// bit-serial square root and runs three 16-step restoring divisions.
// After reset the accumulator store is swept to zero, one entry a cycle,
// across all 1024 entries; busy stays high during the sweep.
module mesh_vertex_normal_engine import mvn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  q_out_t     q;
  back_stat_t stat;

  // Front end: takes command beats and queues them.
  mvn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat),
    .q     (q)
  );

  // Back end: memories, cross product, normalizer and accumulation.
  mvn_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q      (q),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

  // No result may appear while the accumulator sweep is still running.
  `MVN_ASSERT_IMP(a_no_result_in_clear, stat.clearing, !done, "result during clear")
  // The sweep must hold off new commands.
  `MVN_ASSERT_IMP(a_busy_in_clear, stat.clearing, busy, "not busy during clear")
  // A degenerate vector always comes back as the zero vector.
  `MVN_ASSERT_IMP(a_degen_zero, done && result.degenerate,
    result.norm_x == 0 && result.norm_y == 0 && result.norm_z == 0,
    "degenerate result not zero")
  // Every component stays within one unit.
  `MVN_ASSERT_IMP(a_unit_range, done,
    result.norm_x <= 16'sd16384 && result.norm_x >= -16'sd16384 &&
    result.norm_y <= 16'sd16384 && result.norm_y >= -16'sd16384 &&
    result.norm_z <= 16'sd16384 && result.norm_z >= -16'sd16384,
    "normal component out of range")

endmodule

`default_nettype wire
